/* src/psgh_pkg.sv */
`default_nettype none
package psgh_pkg;

  // Byte-lane constants for the zero-byte and backslash tests
  localparam logic [31:0] LANE_ONES  = 32'h0101_0101;
  localparam logic [31:0] LANE_HIGHS = 32'h8080_8080;
  localparam logic [31:0] BSLASH_X4  = 32'h5C5C_5C5C;
  localparam logic [31:0] CASE_MASK  = 32'hDFDF_DFDF;
  localparam logic [31:0] BS_TO_FS   = 32'd45;

  // Scramble multiplier, split into a 32-bit low part and a 12-bit high part
  localparam logic [43:0] SCR_MUL    = 44'hFB8_C4D9_6501;
  localparam logic [31:0] SCR_MUL_LO = SCR_MUL[31:0];
  localparam logic [11:0] SCR_MUL_HI = SCR_MUL[43:32];
  localparam int unsigned SCR_SHIFT  = 24;
  localparam int unsigned SCR_W      = 64 - SCR_SHIFT;

  // Accumulator multiplier and xor-shift distance
  localparam logic [26:0] ACC_MUL    = 27'h633_D5F1;
  localparam int unsigned ACC_XSH    = 61;

  // Length correction multiples (mod 2^64)
  localparam logic [63:0] LEN_MUL_X1 = 64'h00AE_5028_12AA_7333;
  localparam logic [63:0] LEN_MUL_X2 = LEN_MUL_X1 << 1;
  localparam logic [63:0] LEN_MUL_X3 = LEN_MUL_X1 + LEN_MUL_X2;
  localparam logic [63:0] LEN_MUL_X4 = LEN_MUL_X1 << 2;
  localparam logic [63:0] LEN_WRAP   = LEN_MUL_X1 << 32;

  // Terminator byte position within a word
  typedef enum logic [1:0] {
    TPOS_B0 = 2'd0,
    TPOS_B1 = 2'd1,
    TPOS_B2 = 2'd2,
    TPOS_B3 = 2'd3
  } tpos_t;

  // One scrambled word handed to the accumulator
  typedef struct packed {
    logic        term;
    logic [63:0] addend;
  } scr_item_t;

  // Length correction for the bytes ahead of the terminator
  function automatic logic [63:0] len_corr(input tpos_t pos);
    logic [63:0] r;
    case (pos)
      TPOS_B0: r = 64'd0;
      TPOS_B1: r = LEN_MUL_X1;
      TPOS_B2: r = LEN_MUL_X2;
      TPOS_B3: r = LEN_MUL_X3;
      default: r = 64'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/path_string_guid_hash_top.sv */
`default_nettype none
// Path string GUID hash. Feed a NUL-terminated path string as 32-bit
// little-endian beats (first byte in bits 7:0). Each beat is normalized
// (backslash becomes slash, letters fold case) and mixed into a 64-bit
// accumulator; the first beat holding a zero byte ends the string and
// produces one result beat carrying the 64-bit GUID and its 32-bit fold
// (low xor high). Bytes after the terminator are ignored, and the next
// beat starts a new string. The block takes one beat per cycle unless a
// terminating beat waits while the result slot is full; a beat passes an
// input register, the normalize and scramble stage and the accumulator
// stage in that order, and out_tvalid rises once the terminating beat has
// passed them. Throughput is bounded by the accumulator feedback (a constant multiply and add).
module path_string_guid_hash_top (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [31:0]  in_tdata,   // [31:0] text_word
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [95:0]  out_tdata   // [63:0] guid, [95:64] folded_hash
);
  import psgh_pkg::*;

  logic        v1_r;
  logic        v1_nxt;
  logic [31:0] w1_r;
  logic        s2_ready;
  logic        s2_valid;
  scr_item_t   s2_item;
  logic        s2_take;
  logic [63:0] guid;
  logic [31:0] folded_hash;

  // Input register: refill whenever the next stage moves
  always_comb begin
    in_tready = !v1_r || s2_ready;
    v1_nxt    = in_tready ? in_tvalid : v1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      w1_r <= in_tdata;
    end
  end

  psgh_scramble u_scramble (
    .clk        (clk),
    .rst_n      (rst_n),
    .word_valid (v1_r),
    .word       (w1_r),
    .word_ready (s2_ready),
    .item_valid (s2_valid),
    .item       (s2_item),
    .item_take  (s2_take)
  );

  psgh_accum u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (s2_valid),
    .item        (s2_item),
    .item_take   (s2_take),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .guid        (guid),
    .folded_hash (folded_hash)
  );

  assign out_tdata = {folded_hash, guid};

endmodule
`default_nettype wire

/* src/psgh_scramble.sv */
`default_nettype none
module psgh_scramble (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      word_valid,
  input  wire  [31:0]              word,
  output logic                     word_ready,
  output logic                     item_valid,
  output psgh_pkg::scr_item_t      item,
  input  wire                      item_take
);
  import psgh_pkg::*;

  logic [31:0] x;
  logic [31:0] zm;
  logic [31:0] norm;
  logic [31:0] z;
  logic [31:0] low;
  logic [31:0] keep;
  logic [31:0] nsel;
  logic [63:0] p_lo;
  logic [31:0] p_hi;
  logic [63:0] prod;
  logic [SCR_W-1:0] scr;
  tpos_t       pos;
  logic        term;

  logic        valid_r;
  logic        valid_nxt;
  scr_item_t   item_r;
  scr_item_t   item_nxt;

  // Normalize: backslash to slash, fold case
  always_comb begin
    x    = word ^ BSLASH_X4;
    zm   = (~x >> 7) & ((x - LANE_ONES) >> 7) & LANE_ONES;
    norm = (word - 32'(zm * BS_TO_FS)) & CASE_MASK;
  end

  // Find the first zero byte and mask the bytes from it upward
  always_comb begin
    z    = ~word & (word - LANE_ONES) & LANE_HIGHS;
    term = (z != 32'd0);
    low  = z & (32'd0 - z);
    keep = low - 32'd1;
    nsel = term ? (norm & keep) : norm;
    case (low)
      32'h0000_0080: pos = TPOS_B0;
      32'h0000_8000: pos = TPOS_B1;
      32'h0080_0000: pos = TPOS_B2;
      default:       pos = TPOS_B3;
    endcase
  end

  // Scramble: low 64 bits of the constant product, then drop 24 bits
  always_comb begin
    p_lo   = {32'd0, nsel} * {32'd0, SCR_MUL_LO};
    p_hi   = 32'(nsel * {20'd0, SCR_MUL_HI});
    prod   = p_lo + {p_hi, 32'd0};
    scr    = prod[63:SCR_SHIFT];
    item_nxt.term   = term;
    item_nxt.addend = {{SCR_SHIFT{1'b0}}, scr} - (term ? len_corr(pos) : 64'd0);
  end

  // Hold while the accumulator stalls on a terminator
  always_comb begin
    word_ready = !valid_r || item_take;
    valid_nxt  = word_ready ? word_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (word_ready && word_valid) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule
`default_nettype wire

/* src/psgh_accum.sv */
`default_nettype none
module psgh_accum (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      item_valid,
  input  wire psgh_pkg::scr_item_t item,
  output logic                     item_take,
  output logic                     out_tvalid,
  input  wire                      out_tready,
  output logic [63:0]              guid,
  output logic [31:0]              folded_hash
);
  import psgh_pkg::*;

  logic [63:0] acc_r;
  logic [63:0] acc_nxt;
  logic [63:0] lcorr_r;
  logic [63:0] lcorr_nxt;
  logic [29:0] wcnt_r;
  logic [29:0] wcnt_nxt;
  logic        ovalid_r;
  logic        ovalid_nxt;
  logic [63:0] guid_r;
  logic [31:0] fold_r;

  logic [63:0] m_lo;
  logic [31:0] m_hi;
  logic [63:0] s;
  logic [63:0] g;
  logic        out_free;
  logic        load_out;

  // Accumulator times constant, mod 2^64, as two partial products
  always_comb begin
    m_lo = {32'd0, acc_r[31:0]} * {37'd0, ACC_MUL};
    m_hi = 32'(acc_r[63:32] * {5'd0, ACC_MUL});
    s    = m_lo + {m_hi, 32'd0} + item.addend;
    g    = s - lcorr_r;
  end

  // Take a word unless it ends a string and the result slot is full
  always_comb begin
    out_free  = !ovalid_r || out_tready;
    item_take = item_valid && (!item.term || out_free);
    load_out  = item_take && item.term;
  end

  // Advance the running state; clear it after a terminator
  always_comb begin
    acc_nxt   = acc_r;
    lcorr_nxt = lcorr_r;
    wcnt_nxt  = wcnt_r;
    if (item_take) begin
      if (item.term) begin
        acc_nxt   = 64'd0;
        lcorr_nxt = 64'd0;
        wcnt_nxt  = '0;
      end else begin
        acc_nxt   = s ^ (s >> ACC_XSH);
        wcnt_nxt  = wcnt_r + 30'd1;
        lcorr_nxt = lcorr_r + LEN_MUL_X4 - ((&wcnt_r) ? LEN_WRAP : 64'd0);
      end
    end
  end

  // Drop the result beat once taken
  always_comb begin
    if (load_out) begin
      ovalid_nxt = 1'b1;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end else begin
      ovalid_nxt = ovalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= 64'd0;
      lcorr_r  <= 64'd0;
      wcnt_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      acc_r    <= acc_nxt;
      lcorr_r  <= lcorr_nxt;
      wcnt_r   <= wcnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      guid_r <= g;
      fold_r <= g[31:0] ^ g[63:32];
    end
  end

  assign out_tvalid  = ovalid_r;
  assign guid        = guid_r;
  assign folded_hash = fold_r;

endmodule
`default_nettype wire
